// File: hw/rtl/audio_frame_timestamp_queue_top_defines.svh
// Assertion macros for the audio frame timestamp queue.
// Used by the top level only; depends on nothing else.
`ifndef AUDIO_FRAME_TIMESTAMP_QUEUE_TOP_DEFINES_SVH
`define AUDIO_FRAME_TIMESTAMP_QUEUE_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define AFTQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define AFTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/aftq_pkg.sv
// Shared types and codes of the audio frame timestamp queue.
// No dependencies; imported by the top level and used to type the stream interfaces.
`timescale 1ns / 1ps
`default_nettype none

package aftq_pkg;

    // operation codes of an input word
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic [15:0] t_delay;

    // one input word
    typedef struct packed {
        logic               operation;
        logic [15:0]        add_samples;
        logic signed [63:0] frame_pts;
        logic               frame_pts_valid;
        logic [19:0]        remove_samples;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic               queue_full;
        logic               backward_warning;
        logic signed [63:0] out_pts;
        logic               out_pts_valid;
        logic [19:0]        taken_samples;
        logic               empty_warning;
        logic [19:0]        excess_samples;
    } t_out_word;

    // one queue slot as stored in the RAM
    typedef struct packed {
        logic [63:0] pts;
        logic        present;
        logic [16:0] duration;
    } t_entry;

endpackage

`default_nettype wire

// File: hw/rtl/aftq_stream_if.sv
// Valid/ready stream interface carrying one payload word per handshake.
// The payload type is a parameter; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface aftq_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/audio_frame_timestamp_queue_top.sv
// Audio frame timestamp queue: a ring of QUEUE_DEPTH frames, each with a remaining duration
// and an optional start timestamp, all in samples, held in one RAM with a single read port.
// An add word runs through the tail read and backward check, the slot write and the result. A
// remove word runs through the head read, a walk over the k frames it consumes (at most
// QUEUE_DEPTH) that reads and rewrites one RAM slot per cycle, an update of the head timestamp
// when samples are left over, and the result. The result sits in an output register, so the next
// word is accepted while a result still waits. initial_delay is applied
// once, to the first frame added after reset. Depends on aftq_pkg, aftq_stream_if, aftq_ram
// and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "audio_frame_timestamp_queue_top_defines.svh"

module audio_frame_timestamp_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire aftq_pkg::t_delay i_cfg_wr_data,
    aftq_stream_if.sink           i_in,
    aftq_stream_if.source         o_out
);

    import aftq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam int EW = $bits(t_entry);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_EXC  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // slot of the k-th entry from base, modulo the depth
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] ptr);
        return (ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : ptr + AW'(1);
    endfunction

    // control state
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_consumed, n_consumed;
    logic          r_ever, n_ever;
    t_delay        r_delay, n_delay;
    logic          r_ov, n_ov;

    // working registers
    t_in_word      r_req, n_req;
    logic [63:0]   r_p, n_p;
    logic [19:0]   r_rem, n_rem;
    logic [19:0]   r_removed, n_removed;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_last_ptr, n_last_ptr;
    logic          r_last_nz, n_last_nz;
    t_out_word     r_res, n_res;
    t_out_word     r_out, n_out;

    // RAM port signals
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    t_entry        ram_wr_entry;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [EW-1:0] ram_rd_data;
    t_entry        rd_entry;

    // walk step values
    t_delay        delay_eff;
    logic [19:0]   take;
    logic [16:0]   left;
    logic [CW-1:0] retired;

    aftq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_entry),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rd_entry    = t_entry'(ram_rd_data);
    assign delay_eff   = r_consumed ? '0 : r_delay;
    assign take        = (20'(rd_entry.duration) < r_rem) ? 20'(rd_entry.duration) : r_rem;
    assign left        = rd_entry.duration - take[16:0];
    assign retired     = r_idx - CW'(r_last_nz);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_consumed   = r_consumed;
        n_ever       = r_ever;
        n_delay      = r_delay;
        n_ov         = r_ov;
        n_req        = r_req;
        n_p          = r_p;
        n_rem        = r_rem;
        n_removed    = r_removed;
        n_idx        = r_idx;
        n_ptr        = r_ptr;
        n_last_ptr   = r_last_ptr;
        n_last_nz    = r_last_nz;
        n_res        = r_res;
        n_out        = r_out;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_ptr;
        ram_wr_entry = rd_entry;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_head;

        if (i_cfg_wr_en) begin
            n_delay = i_cfg_wr_data;
        end

        // result register drains on its own handshake
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_req     = i_in.data;
                    n_p       = i_in.data.frame_pts - 64'(delay_eff);
                    ram_rd_en = 1'b1;
                    if (i_in.data.operation == OP_ADD) begin
                        // tail slot for the backward check
                        ram_rd_addr = (r_count == '0) ? r_head
                                                      : slot_add(r_head, r_count - CW'(1));
                        n_state     = S_ADD;
                    end else begin
                        ram_rd_addr = r_head;
                        n_state     = S_HEAD;
                    end
                end
            end
            S_ADD: begin
                n_res = '0;
                if (r_count == DEPTH_C) begin
                    n_res.queue_full = 1'b1;
                end else begin
                    ram_wr_en             = 1'b1;
                    ram_wr_addr           = slot_add(r_head, r_count);
                    ram_wr_entry.duration = 17'(r_req.add_samples) + 17'(delay_eff);
                    ram_wr_entry.present  = r_req.frame_pts_valid;
                    ram_wr_entry.pts      = r_req.frame_pts_valid ? r_p : '0;
                    n_res.backward_warning = r_req.frame_pts_valid && (r_count != '0)
                        && rd_entry.present && ($signed(rd_entry.pts) >= $signed(r_p));
                    n_count    = r_count + CW'(1);
                    n_consumed = 1'b1;
                    n_ever     = 1'b1;
                end
                n_state = S_DONE;
            end
            S_HEAD: begin
                // head timestamp before any removal
                n_res = '0;
                if ((r_count != '0 || r_ever) && rd_entry.present) begin
                    n_res.out_pts       = rd_entry.pts;
                    n_res.out_pts_valid = 1'b1;
                end
                n_res.empty_warning = (r_count == '0);
                n_rem      = r_req.remove_samples;
                n_removed  = '0;
                n_idx      = '0;
                n_ptr      = r_head;
                n_last_ptr = r_head;
                n_last_nz  = 1'b0;
                n_state    = S_WALK;
            end
            S_WALK: begin
                if (r_rem != '0 && r_idx < r_count) begin
                    // consume from the entry at r_ptr, prefetch the next one
                    ram_wr_en             = 1'b1;
                    ram_wr_addr           = r_ptr;
                    ram_wr_entry.duration = left;
                    ram_wr_entry.present  = rd_entry.present;
                    ram_wr_entry.pts      = rd_entry.present ? rd_entry.pts + 64'(take)
                                                             : rd_entry.pts;
                    n_rem       = r_rem - take;
                    n_removed   = r_removed + take;
                    n_last_nz   = (left != '0);
                    n_last_ptr  = r_ptr;
                    n_ptr       = slot_inc(r_ptr);
                    n_idx       = r_idx + CW'(1);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = slot_inc(r_ptr);
                end else begin
                    // retire drained entries; a partly used one stays at the head
                    n_count = r_count - retired;
                    if (retired < r_count) begin
                        n_head = r_last_nz ? r_last_ptr : r_ptr;
                    end
                    n_res.taken_samples  = r_removed;
                    n_res.excess_samples = r_rem;
                    if (r_rem != '0) begin
                        // queue fully drained: head slot unchanged, reread it
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_head;
                        n_state     = S_EXC;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_EXC: begin
                // leftover samples advance the kept head timestamp
                if (rd_entry.present) begin
                    ram_wr_en        = 1'b1;
                    ram_wr_addr      = r_head;
                    ram_wr_entry.pts = rd_entry.pts + 64'(r_rem);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_consumed <= 1'b0;
            r_ever     <= 1'b0;
            r_delay    <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_consumed <= n_consumed;
            r_ever     <= n_ever;
            r_delay    <= n_delay;
            r_ov       <= n_ov;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_p        <= n_p;
        r_rem      <= n_rem;
        r_removed  <= n_removed;
        r_idx      <= n_idx;
        r_ptr      <= n_ptr;
        r_last_ptr <= n_last_ptr;
        r_last_nz  <= n_last_nz;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // checks
    `AFTQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_C, "entry count above depth")
    `AFTQ_ASSERT(a_walk_bound, i_clk, i_rst_n,
        (r_state != S_WALK) || (r_idx <= r_count), "walk index past entry count")
    `AFTQ_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n,
        (r_state == S_ADD) && (r_count == DEPTH_C),
        $stable(r_count) && $stable(r_head), "refused add changed the queue")
    `AFTQ_ASSERT(a_remove_sum, i_clk, i_rst_n,
        (r_state != S_DONE) || (r_req.operation != OP_REMOVE)
        || ((21'(r_res.taken_samples) + 21'(r_res.excess_samples))
            == 21'(r_req.remove_samples)),
        "removed plus excess differs from request")

endmodule

`default_nettype wire

// File: hw/rtl/aftq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module aftq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]              o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
